/* rtl/ole_pkg.sv */
`timescale 1ns / 1ps
package ole_pkg;
  localparam int unsigned Capacity  = 64;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned IdxW      = $clog2(Capacity);
  localparam int unsigned LenW      = $clog2(Capacity + 1);
  localparam int unsigned QDepth    = 2;

  typedef enum logic [2:0] {
    OpInsFront = 3'd0,
    OpInsRear  = 3'd1,
    OpInsPos   = 3'd2,
    OpDelFront = 3'd3,
    OpDelRear  = 3'd4,
    OpDelValue = 3'd5,
    OpSearch   = 3'd6,
    OpClear    = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StEmpty    = 2'd1,
    StNotFound = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef struct packed {
    op_e                  op;
    logic [DataWidth-1:0] key;
    logic [15:0]          position;
  } cmd_t;
endpackage

/* rtl/ole_if.sv */
`timescale 1ns / 1ps
interface ole_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic signed [31:0] value;
  logic [15:0] position;
  modport source (output valid, operation, value, position, input ready);
  modport sink (input valid, operation, value, position, output ready);
endinterface

interface ole_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] result_value;
  logic [5:0]  found_index;
  logic [6:0]  list_length;
  modport source (output valid, status, result_value, found_index, list_length,
                  input ready);
  modport sink (input valid, status, result_value, found_index, list_length,
                output ready);
endinterface

/* rtl/ordered_list_engine.sv */
`timescale 1ns / 1ps
// channel | direction | fields
// req     | in        | operation, value, position
// rsp     | out       | status, result_value, found_index, list_length
// A request passes through the back end in steps: capture with a parallel
// compare of all cells, a shift-in-place update, then the response register.
// A two-entry queue keeps taking requests while a response stalls, until it fills.
// Reset empties the list at once; no clearing pass.
module ordered_list_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  ole_req_if.sink   req,
  ole_rsp_if.source rsp
);
  logic          cmd_valid, cmd_ready;
  ole_pkg::cmd_t cmd;

  ole_front u_front (
    .clk_i, .rst_ni, .req,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  ole_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd), .rsp
  );
endmodule

/* rtl/ole_front.sv */
`timescale 1ns / 1ps
module ole_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  ole_req_if.sink       req,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output ole_pkg::cmd_t cmd_o
);
  ole_pkg::cmd_t cmd_q [ole_pkg::QDepth];
  logic          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;
  ole_pkg::cmd_t in_cmd;

  always_comb begin
    in_cmd.op       = ole_pkg::op_e'(req.operation);
    in_cmd.key      = ole_pkg::DataWidth'(req.value);
    in_cmd.position = req.position;
  end

  assign req.ready   = (cnt_q != 2'(ole_pkg::QDepth));
  assign push        = req.valid && req.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = cmd_q[rd_ptr_q];
  assign wr_ptr_d    = push ? ~wr_ptr_q : wr_ptr_q;
  assign rd_ptr_d    = pop ? ~rd_ptr_q : rd_ptr_q;
  assign cnt_d       = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i) begin
    if (push) cmd_q[wr_ptr_q] <= in_cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end
endmodule

/* rtl/ole_back.sv */
`timescale 1ns / 1ps
module ole_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  ole_pkg::cmd_t cmd_i,
  ole_rsp_if.source     rsp
);
  localparam int unsigned N  = ole_pkg::Capacity;
  localparam int unsigned DW = ole_pkg::DataWidth;
  localparam int unsigned IW = ole_pkg::IdxW;
  localparam int unsigned LW = ole_pkg::LenW;
  localparam logic [1:0] S_IDLE = 2'd0, S_EXEC = 2'd1, S_OUT = 2'd2;

  logic [DW-1:0] cell_q [N];
  logic [DW-1:0] cell_d [N];
  logic [LW-1:0] len_q, len_d;
  logic [1:0]    state_q, state_d;
  ole_pkg::cmd_t cmd_q;
  logic [N-1:0]  hit_q;
  logic [N-1:0]  first_hit;
  logic          any_hit;
  logic [IW-1:0] hit_idx;
  logic [1:0]    st_q, st_d;
  logic [DW-1:0] rv_q, rv_d;
  logic [IW-1:0] fi_q, fi_d;
  logic [IW-1:0] tgt;
  logic          do_ins, do_del;
  logic          take;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign take        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    any_hit   = |hit_q;
    first_hit = hit_q & (~hit_q + N'(1));
    hit_idx   = '0;
    for (int i = 0; i < N; i++) begin
      if (first_hit[i]) hit_idx = hit_idx | IW'(i);
    end
  end

  always_comb begin
    st_d   = ole_pkg::StOk;
    rv_d   = '0;
    fi_d   = '0;
    tgt    = '0;
    do_ins = 1'b0;
    do_del = 1'b0;
    len_d  = len_q;
    case (cmd_q.op)
      ole_pkg::OpInsFront, ole_pkg::OpInsRear, ole_pkg::OpInsPos: begin
        if (len_q == LW'(N)) begin
          st_d = ole_pkg::StFull;
        end else begin
          do_ins = 1'b1;
          len_d  = len_q + LW'(1);
          if (cmd_q.op == ole_pkg::OpInsFront) tgt = '0;
          else if (cmd_q.op == ole_pkg::OpInsRear || 16'(len_q) <= cmd_q.position)
            tgt = IW'(len_q);
          else tgt = IW'(cmd_q.position);
        end
      end
      ole_pkg::OpDelFront, ole_pkg::OpDelRear: begin
        if (len_q == '0) begin
          st_d = ole_pkg::StEmpty;
        end else begin
          do_del = 1'b1;
          len_d  = len_q - LW'(1);
          tgt    = (cmd_q.op == ole_pkg::OpDelFront) ? '0 : IW'(len_q - LW'(1));
        end
      end
      ole_pkg::OpDelValue, ole_pkg::OpSearch: begin
        if (len_q == '0) begin
          st_d = ole_pkg::StEmpty;
        end else if (!any_hit) begin
          st_d = ole_pkg::StNotFound;
        end else if (cmd_q.op == ole_pkg::OpSearch) begin
          fi_d = hit_idx;
        end else begin
          do_del = 1'b1;
          len_d  = len_q - LW'(1);
          tgt    = hit_idx;
        end
      end
      default: len_d = '0;
    endcase
    if (do_del) rv_d = cell_q[tgt];
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      cell_d[i] = cell_q[i];
      if (do_ins) begin
        if (IW'(i) == tgt) cell_d[i] = cmd_q.key;
        else if (IW'(i) > tgt && i > 0) cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
      end else if (do_del) begin
        if (IW'(i) >= tgt && i < N - 1) cell_d[i] = cell_q[(i < N - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (take) state_d = S_EXEC;
      S_EXEC:  state_d = S_OUT;
      S_OUT:   if (rsp.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_i;
      for (int i = 0; i < N; i++) begin
        hit_q[i] <= (cell_q[i] == cmd_i.key) && (LW'(i) < len_q);
      end
    end
    if (state_q == S_EXEC) begin
      cell_q <= cell_d;
      rv_q   <= rv_d;
      fi_q   <= fi_d;
      st_q   <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC) len_q <= len_d;
    end
  end

  assign rsp.valid        = (state_q == S_OUT);
  assign rsp.status       = st_q;
  assign rsp.result_value = 32'(signed'(rv_q));
  assign rsp.found_index  = 6'(fi_q);
  assign rsp.list_length  = 7'(len_q);
endmodule
